// ===== src/wfd_pkg.sv =====
// Package with the shared codes and the delimiter test of the word frequency dictionary.
package wfd_pkg;

   localparam logic [1:0] FUNC_COUNT = 2'd0;
   localparam logic [1:0] FUNC_QUERY = 2'd1;
   localparam logic [1:0] FUNC_ADD   = 2'd2;

   localparam logic [2:0] ST_COUNTED   = 3'd0;
   localparam logic [2:0] ST_ADDED     = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_FOUND     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_EXISTS    = 3'd5;
   localparam logic [2:0] ST_HALTED    = 3'd6;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   function automatic logic is_delim(input logic [7:0] b);
      logic d;
      d = 1'b0;
      if (b inside {8'h00, [8'h09:8'h0D], [8'h20:8'h2F], [8'h3A:8'h40],
                    [8'h5B:8'h60], [8'h7B:8'h7E]}) begin
         d = 1'b1;
      end
      return d;
   endfunction

endpackage

// ===== src/wfd_cell.sv =====
// One dictionary cell: a stored word and its count, shifted to the neighbor when the ring turns.
module wfd_cell #(
   parameter int KEY_W = 152
) (
   input  logic             clock,
   input  logic             shift,
   input  logic [KEY_W-1:0] key_in,
   input  logic [31:0]      count_in,
   output logic [KEY_W-1:0] key_out,
   output logic [31:0]      count_out
);
   logic [KEY_W-1:0] key_ff;
   logic [31:0]      count_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         key_ff   <= key_in;
         count_ff <= count_in;
      end
   end

   assign key_out   = key_ff;
   assign count_out = count_ff;
endmodule

// ===== src/word_frequency_dictionary_top.sv =====
// Top level of the word frequency dictionary: word gathering, cell ring and scan control.
//
//   Channel   Ports            Handshake
//   request   req_*            start high while busy low
//   result    rsp_*            rsp_strobe high for one cycle
//
// A byte that does not complete a word is stored in the pending word and the block stays idle.
// A byte that completes a word starts a scan of the cell ring: the ring turns once
// past the head cell, which compares, counts and inserts, then the result is formed.
// The result appears in the same cycle that busy falls.
// Reset clears the control state; the cells hold no data until words are inserted.
// The receiver cannot stall, so no result is ever held back.
module word_frequency_dictionary_top #(
   parameter int ENTRIES        = 1024,
   parameter int MAX_WORD_BYTES = 19,
   localparam int IDX_W = $clog2(ENTRIES),
   localparam int CNT_W = $clog2(ENTRIES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_func,
   input  logic [7:0]       req_data_byte,
   input  logic             req_end_of_input,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_status,
   output logic [IDX_W-1:0] rsp_entry_index,
   output logic [31:0]      rsp_frequency,
   output logic [CNT_W-1:0] rsp_entry_count,
   output logic [4:0]       rsp_word_length
);
   import wfd_pkg::*;

   localparam int KEY_W = MAX_WORD_BYTES * 8;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_type;

   state_type        state_ff;
   logic [KEY_W-1:0] pend_ff, pend_in;
   logic [4:0]       len_ff, len_in;
   logic [KEY_W-1:0] key_ff;
   logic [4:0]       wlen_ff;
   logic [1:0]       func_ff;
   logic [IDX_W-1:0] pos_ff;
   logic [CNT_W-1:0] used_ff;
   logic             halted_ff, hit_ff, ins_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [31:0]      freq_ff;
   logic             rsp_strobe_ff;
   logic [2:0]       rsp_status_ff;
   logic [IDX_W-1:0] rsp_index_ff;
   logic [31:0]      rsp_freq_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic [4:0]       rsp_len_ff;

   logic [KEY_W-1:0] ring_key   [ENTRIES];
   logic [31:0]      ring_count [ENTRIES];
   logic [KEY_W-1:0] head_key_in;
   logic [31:0]      head_count_in;
   logic             shift;

   logic accept, ends_word, finish, act_count, act_add, halt_mode;
   logic valid_slot, match, insert;
   logic [31:0] new_count;

   assign accept    = start && (state_ff == S_IDLE);
   assign ends_word = req_end_of_input || is_delim(req_data_byte);
   assign shift     = (state_ff == S_SCAN);

   always_comb begin
      pend_in = pend_ff;
      len_in  = len_ff;
      finish  = 1'b0;
      if (ends_word) begin
         finish = (len_ff != 5'd0);
      end else begin
         for (int j = 0; j < MAX_WORD_BYTES; j++) begin
            if (len_ff == 5'(j)) begin
               pend_in[j*8 +: 8] = req_data_byte;
            end
         end
         len_in = len_ff + 5'd1;
         finish = (len_in >= 5'(MAX_WORD_BYTES));
      end
   end

   assign halt_mode  = (func_ff == FUNC_COUNT) && halted_ff;
   assign act_count  = (func_ff == FUNC_COUNT) && !halted_ff;
   assign act_add    = (func_ff == FUNC_ADD);
   assign valid_slot = {1'b0, pos_ff} < (IDX_W + 1)'(used_ff);
   assign match      = valid_slot && !halt_mode && (ring_key[0] == key_ff);
   assign insert     = !hit_ff && !ins_ff && (act_count || act_add)
                       && ((IDX_W + 1)'(used_ff) == {1'b0, pos_ff});

   always_comb begin
      new_count = ring_count[0];
      if (match && act_count && ring_count[0] != COUNT_MAX) begin
         new_count = ring_count[0] + 32'd1;
      end
      head_key_in   = ring_key[0];
      head_count_in = new_count;
      if (insert) begin
         head_key_in   = key_ff;
         head_count_in = 32'd1;
      end
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      wfd_cell #(.KEY_W(KEY_W)) u_cell (
         .clock     (clock),
         .shift     (shift),
         .key_in    ((i == ENTRIES - 1) ? head_key_in : ring_key[(i + 1) % ENTRIES]),
         .count_in  ((i == ENTRIES - 1) ? head_count_in : ring_count[(i + 1) % ENTRIES]),
         .key_out   (ring_key[i]),
         .count_out (ring_count[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_ff       <= '0;
         len_ff        <= '0;
         used_ff       <= '0;
         halted_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (finish) begin
                     key_ff   <= pend_in;
                     wlen_ff  <= len_in;
                     func_ff  <= req_func;
                     pend_ff  <= '0;
                     len_ff   <= '0;
                     pos_ff   <= '0;
                     hit_ff   <= 1'b0;
                     ins_ff   <= 1'b0;
                     idx_ff   <= '0;
                     freq_ff  <= '0;
                     state_ff <= S_SCAN;
                  end else begin
                     pend_ff <= pend_in;
                     len_ff  <= len_in;
                  end
               end
            end
            S_SCAN: begin
               if (match) begin
                  hit_ff  <= 1'b1;
                  idx_ff  <= pos_ff;
                  freq_ff <= new_count;
               end
               if (insert) begin
                  ins_ff  <= 1'b1;
                  idx_ff  <= pos_ff;
                  freq_ff <= 32'd1;
                  used_ff <= used_ff + CNT_W'(1);
               end
               pos_ff <= pos_ff + IDX_W'(1);
               if (pos_ff == IDX_W'(ENTRIES - 1)) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               rsp_strobe_ff <= 1'b1;
               rsp_index_ff  <= '0;
               rsp_freq_ff   <= '0;
               rsp_count_ff  <= used_ff;
               rsp_len_ff    <= wlen_ff;
               if (halt_mode) begin
                  rsp_status_ff <= ST_HALTED;
               end else if (hit_ff) begin
                  rsp_index_ff <= idx_ff;
                  rsp_freq_ff  <= freq_ff;
                  if (act_count) begin
                     rsp_status_ff <= ST_COUNTED;
                  end else if (act_add) begin
                     rsp_status_ff <= ST_EXISTS;
                  end else begin
                     rsp_status_ff <= ST_FOUND;
                  end
               end else if (ins_ff) begin
                  rsp_index_ff  <= idx_ff;
                  rsp_freq_ff   <= freq_ff;
                  rsp_status_ff <= ST_ADDED;
               end else if (act_count || act_add) begin
                  rsp_status_ff <= ST_FULL;
                  if (act_count) begin
                     halted_ff <= 1'b1;
                  end
               end else begin
                  rsp_status_ff <= ST_NOT_FOUND;
               end
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_frequency   = rsp_freq_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_word_length = rsp_len_ff;
endmodule

// ===== src/wfd_checker.sv =====
// Port checker for the word frequency dictionary, bound to the top level.
module wfd_checker #(
   parameter int ENTRIES = 1024,
   localparam int IDX_W = $clog2(ENTRIES),
   localparam int CNT_W = $clog2(ENTRIES + 1)
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic [1:0]       req_func,
   input logic [7:0]       req_data_byte,
   input logic             req_end_of_input,
   input logic             rsp_strobe,
   input logic [2:0]       rsp_status,
   input logic [IDX_W-1:0] rsp_entry_index,
   input logic [31:0]      rsp_frequency,
   input logic [CNT_W-1:0] rsp_entry_count,
   input logic [4:0]       rsp_word_length
);
   import wfd_pkg::*;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Two results in consecutive cycles.");

   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("Result shown while a request is in progress.");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == ST_HALTED || rsp_status == ST_FULL
                     || rsp_status == ST_NOT_FOUND)
      |-> (rsp_frequency == 32'd0) && (rsp_entry_index == '0))
      else $error("Absent word reported with a slot or a count.");

   a_present_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == ST_COUNTED || rsp_status == ST_ADDED
                     || rsp_status == ST_FOUND || rsp_status == ST_EXISTS)
      |-> (rsp_frequency != 32'd0) && (rsp_entry_count != '0)
          && (rsp_word_length != 5'd0))
      else $error("Present word reported with a zero count.");
endmodule

bind word_frequency_dictionary_top wfd_checker #(.ENTRIES(ENTRIES)) u_wfd_checker (.*);
